### hw/rtl/priority_sorted_dispatch_queue_defines.svh
// Assertion macros used by the priority dispatch queue top level.
`ifndef PRIORITY_SORTED_DISPATCH_QUEUE_DEFINES_SVH
`define PRIORITY_SORTED_DISPATCH_QUEUE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSDQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/psdq_pkg.sv
// Types and constants of the priority dispatch queue.
package psdq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int PID_W       = 22;
    localparam int PRIO_W      = 8;
    localparam int WAIT_W      = 5;

    localparam logic [PRIO_W-1:0] THRESHOLD_RESET = PRIO_W'(3);
    localparam logic [CNT_W-1:0]  MIN_WAITING     = CNT_W'(1);

    typedef enum logic [1:0] {
        ST_INSERTED   = 2'd0,
        ST_DROPPED    = 2'd1,
        ST_DISPATCHED = 2'd2,
        ST_HELD       = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_POP    = 2'd2
    } t_cell_op;

    typedef struct packed {
        logic [PID_W-1:0]  pid;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    typedef struct packed {
        t_cell_op op;
        t_entry   ins_entry;
    } t_cell_ctl;

    typedef struct packed {
        logic              action;
        logic [PID_W-1:0]  new_pid;
        logic [PRIO_W-1:0] new_priority;
    } t_in_beat;

    typedef struct packed {
        t_status           status;
        logic [PID_W-1:0]  granted_pid;
        logic [WAIT_W-1:0] waiting_count;
    } t_out_beat;

endpackage

### hw/rtl/psdq_cell.sv
// One slot of the sorted queue, exchanging entries with its two neighbors.
module psdq_cell
    import psdq_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_slot_valid,
    input  logic      i_left_go,
    input  t_entry    i_left_entry,
    input  t_entry    i_right_entry,
    output logic      o_go,
    output t_entry    o_entry
);

    t_entry r_entry;
    t_entry n_entry;

    // The new entry belongs at or ahead of this slot unless this slot
    // holds a strictly higher priority.
    assign o_go    = !(i_slot_valid && (r_entry.prio > i_ctl.ins_entry.prio));
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_ctl.op)
            OP_INSERT: begin
                if (o_go) begin
                    n_entry = i_left_go ? i_left_entry : i_ctl.ins_entry;
                end
            end
            OP_POP: begin
                n_entry = i_right_entry;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

### hw/rtl/priority_sorted_dispatch_queue.sv
// Priority dispatch queue: top level with control and the row of slot cells.
// The result of an accepted item is registered and appears on o_out with o_done in the next cycle.
// Throughput: one item per cycle; the cells take their new entries in the accept cycle.
// busy is low outside reset, so start may be high in every cycle.
// Reset (synchronous, active low) empties the queue and sets the threshold to 3.
// The receiver cannot stall: each result is valid for exactly one cycle.
`include "priority_sorted_dispatch_queue_defines.svh"

module priority_sorted_dispatch_queue
    import psdq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_in_beat          i_in,
    input  logic              i_cfg_we,
    input  logic [PRIO_W-1:0] i_cfg_wdata,
    output logic              o_done,
    output t_out_beat         o_out
);

    logic [CNT_W-1:0]  r_occ;
    logic [CNT_W-1:0]  n_occ;
    logic [PRIO_W-1:0] r_thr;
    logic              r_done;
    t_out_beat         r_out;
    t_out_beat         n_out;
    logic              w_accept;
    logic              w_full;
    logic              w_can_pop;
    t_cell_ctl         w_ctl;

    logic   [QUEUE_DEPTH-1:0] w_slot_valid;
    logic   [QUEUE_DEPTH-1:0] w_go;
    t_entry                   w_entry [QUEUE_DEPTH];

    // The block takes no beat while it is held in reset.
    assign busy     = !i_rst_n;
    assign w_accept = start && !busy;

    // Occupancy is the only bookkeeping: slots below it are live.
    assign w_full    = (r_occ == CNT_W'(QUEUE_DEPTH));
    assign w_can_pop = (r_occ > MIN_WAITING) && (w_entry[0].prio >= r_thr);

    // Decide what every cell does this cycle, and the result of the beat.
    always_comb begin
        w_ctl.op                 = OP_HOLD;
        w_ctl.ins_entry.pid      = i_in.new_pid;
        w_ctl.ins_entry.prio     = i_in.new_priority;
        n_occ                    = r_occ;
        n_out.status             = ST_HELD;
        n_out.granted_pid        = '0;
        if (!i_in.action) begin
            if (w_full) begin
                n_out.status = ST_DROPPED;
            end else begin
                w_ctl.op     = w_accept ? OP_INSERT : OP_HOLD;
                n_occ        = r_occ + CNT_W'(1);
                n_out.status = ST_INSERTED;
            end
        end else if (w_can_pop) begin
            w_ctl.op          = w_accept ? OP_POP : OP_HOLD;
            n_occ             = r_occ - CNT_W'(1);
            n_out.status      = ST_DISPATCHED;
            n_out.granted_pid = w_entry[0].pid;
        end
        // The count port keeps only its low bits for deep queues.
        n_out.waiting_count = WAIT_W'(n_occ);
    end

    // The row of cells. The head is cell 0; inserts ripple toward the tail
    // and a dispatch shifts every entry one slot toward the head.
    for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
        logic   w_left_go;
        t_entry w_left_entry;
        t_entry w_right_entry;

        assign w_slot_valid[k] = (r_occ > CNT_W'(k));

        if (k == 0) begin : g_head
            assign w_left_go    = 1'b0;
            assign w_left_entry = '0;
        end else begin : g_body
            assign w_left_go    = w_go[k-1];
            assign w_left_entry = w_entry[k-1];
        end

        if (k == QUEUE_DEPTH - 1) begin : g_tail
            assign w_right_entry = '0;
        end else begin : g_inner
            assign w_right_entry = w_entry[k+1];
        end

        psdq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_slot_valid  (w_slot_valid[k]),
            .i_left_go     (w_left_go),
            .i_left_entry  (w_left_entry),
            .i_right_entry (w_right_entry),
            .o_go          (w_go[k]),
            .o_entry       (w_entry[k])
        );
    end

    // Control state: occupancy, threshold and the result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ  <= '0;
            r_thr  <= THRESHOLD_RESET;
            r_done <= 1'b0;
        end else begin
            r_done <= w_accept;
            if (w_accept) begin
                r_occ <= n_occ;
            end
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
        end
    end

    // The result beat itself needs no reset; o_done qualifies it.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign o_done = r_done;
    assign o_out  = r_out;

    `PSDQ_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, w_accept, o_done, "result beat missing after accepted item")
    `PSDQ_ASSERT_SAME(a_pid_zero_unless_grant, i_clk, i_rst_n, o_done && (o_out.status != ST_DISPATCHED), o_out.granted_pid == '0, "granted pid nonzero without dispatch")
    `PSDQ_ASSERT_SAME(a_occ_bounded, i_clk, i_rst_n, 1'b1, r_occ <= CNT_W'(QUEUE_DEPTH), "occupancy beyond queue depth")
    `PSDQ_ASSERT_SAME(a_head_sorted, i_clk, i_rst_n, r_occ > MIN_WAITING, w_entry[0].prio >= w_entry[1].prio, "head entry out of priority order")

endmodule

### tb/tb_top.sv
// Self-checking testbench for the priority dispatch queue: directed and random beats.
`timescale 1ns / 1ps

module tb_top;
    import psdq_pkg::*;

    // Input action codes carried in the one-bit action field.
    localparam logic ACT_REGISTER = 1'b0;
    localparam logic ACT_DISPATCH = 1'b1;

    localparam int RANDOM_BEATS = 1900;
    localparam int PHASE_BEATS  = 190;
    localparam int MAX_GAP      = 14;
    localparam int MAX_REPORTS  = 10;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_in_beat          i_in;
    logic              i_cfg_we;
    logic [PRIO_W-1:0] i_cfg_wdata;
    logic              o_done;
    t_out_beat         o_out;

    priority_sorted_dispatch_queue dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_done     (o_done),
        .o_out      (o_out)
    );

    // Shadow copy of the sorted queue, head in slot 0, and of the threshold register.
    t_entry            shadow_slots [QUEUE_DEPTH];
    int                shadow_count;
    logic [PRIO_W-1:0] shadow_threshold;

    // Results predicted for accepted beats, oldest first.
    t_out_beat pending_results [$];

    int err_count;
    int n_inserted;
    int n_dropped;
    int n_dispatched;
    int n_held;
    int n_threshold_writes;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit on the run. The slowest legal run is far below this.
    initial begin
        #5_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    // Works out the result of one beat and advances the shadow queue. A new entry
    // goes ahead of every entry of equal or lower priority, so among ties the
    // newest is served first. A dispatch needs two or more entries and a head
    // priority at or above the threshold; the grant field stays zero otherwise.
    function automatic t_out_beat predict_dispatch(t_in_beat b);
        t_out_beat r;
        int        pos;
        int        k;
        r = '0;
        if (b.action == ACT_REGISTER) begin
            if (shadow_count >= QUEUE_DEPTH) begin
                r.status = ST_DROPPED;
            end else begin
                pos = 0;
                while (pos < shadow_count && shadow_slots[pos].prio > b.new_priority)
                    pos++;
                for (k = shadow_count; k > pos; k--)
                    shadow_slots[k] = shadow_slots[k-1];
                shadow_slots[pos].pid  = b.new_pid;
                shadow_slots[pos].prio = b.new_priority;
                shadow_count++;
                r.status = ST_INSERTED;
            end
        end else if (shadow_count > int'(MIN_WAITING)
                     && shadow_slots[0].prio >= shadow_threshold) begin
            r.granted_pid = shadow_slots[0].pid;
            for (k = 1; k < shadow_count; k++)
                shadow_slots[k-1] = shadow_slots[k];
            shadow_count--;
            r.status = ST_DISPATCHED;
        end else begin
            r.status = ST_HELD;
        end
        r.waiting_count = WAIT_W'(shadow_count);
        return r;
    endfunction

    // Sends one beat after an idle gap. Start is left high on return so that
    // back-to-back beats never lower and raise it in the same time step; the
    // drain task lowers it once a run of beats is over.
    task automatic send_beat(input logic act, input logic [PID_W-1:0] pid,
                             input logic [PRIO_W-1:0] prio, input int gap);
        t_in_beat  b;
        t_out_beat r;
        b.action       = act;
        b.new_pid      = pid;
        b.new_priority = prio;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_in  <= b;
        do @(posedge i_clk); while (busy);
        r = predict_dispatch(b);
        pending_results.push_back(r);
        case (r.status)
            ST_INSERTED:   n_inserted++;
            ST_DROPPED:    n_dropped++;
            ST_DISPATCHED: n_dispatched++;
            default:       n_held++;
        endcase
    endtask

    // Stops sending and waits for every outstanding result, with some margin.
    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Writes the threshold register. Only called while nothing is outstanding.
    task automatic write_threshold(input logic [PRIO_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        shadow_threshold = value;
        n_threshold_writes++;
    endtask

    function automatic int random_gap();
        return $urandom_range(MAX_GAP);
    endfunction

    // Result checker. Every result is valid for exactly one cycle and must match
    // the oldest prediction field by field.
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("tb_top: unexpected result status=%0d pid=%0d count=%0d",
                             o_out.status, o_out.granted_pid, o_out.waiting_count);
            end else begin
                want = pending_results.pop_front();
                if (o_out.status !== want.status
                    || o_out.granted_pid !== want.granted_pid
                    || o_out.waiting_count !== want.waiting_count) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("tb_top: mismatch exp %0d/%0d/%0d got %0d/%0d/%0d (st/pid/cnt)",
                                 want.status, want.granted_pid, want.waiting_count,
                                 o_out.status, o_out.granted_pid, o_out.waiting_count);
                end
            end
        end
    end

    // Right after reset: the threshold is 3, so a dispatch holds on an empty
    // queue, on a single entry, and on a head below the threshold, and is
    // granted once a head of priority 3 arrives with more than one entry.
    task automatic test_reset_holds();
        send_beat(ACT_DISPATCH, '0, '0, 0);
        send_beat(ACT_REGISTER, '0, 8'd0, 0);
        send_beat(ACT_DISPATCH, '1, '1, random_gap());
        send_beat(ACT_REGISTER, '1, 8'd2, 0);
        send_beat(ACT_DISPATCH, '0, '0, 0);
        send_beat(ACT_REGISTER, 22'h2AAAAA, 8'd3, random_gap());
        send_beat(ACT_DISPATCH, '0, '0, 0);
        drain_results();
    endtask

    // Fills the queue with extreme identifiers and priorities, ties among them,
    // checks the drop of an insert into a full queue, then the strictest
    // threshold against a head of the top priority.
    task automatic test_full_queue();
        int n;
        write_threshold(8'd0);
        n = 0;
        while (shadow_count < QUEUE_DEPTH) begin
            case (n % 4)
                0:       send_beat(ACT_REGISTER, '1, 8'd255, 0);
                1:       send_beat(ACT_REGISTER, PID_W'(n), 8'd0, 0);
                2:       send_beat(ACT_REGISTER, 22'h155555, 8'd128, random_gap());
                default: send_beat(ACT_REGISTER, PID_W'($urandom), 8'd255, 0);
            endcase
            n++;
        end
        send_beat(ACT_REGISTER, 22'h3C3C3C, 8'd200, 0);
        drain_results();
        write_threshold(8'd255);
        send_beat(ACT_DISPATCH, '0, '0, 0);
        send_beat(ACT_DISPATCH, '0, '0, 0);
        drain_results();
    endtask

    // Random traffic in phases, each under its own threshold. Priorities lean
    // toward the threshold and its neighbors to hit the boundary and ties, and
    // the insert share rises when the queue runs low. Some stretches run with
    // no idle cycles at all. Each phase ends with a full drain before the next
    // register write, which is also where the sender waits for every result.
    task automatic test_random_traffic();
        int                sent;
        int                phase;
        int                i;
        bit                burst;
        logic              act;
        logic [PRIO_W-1:0] prio;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_BEATS) begin
            case (phase)
                0:       write_threshold(8'd0);
                1:       write_threshold(8'd255);
                2:       write_threshold(8'd1);
                3:       write_threshold(8'd254);
                default: write_threshold($urandom_range(3) == 0 ?
                                         PRIO_W'($urandom) : PRIO_W'($urandom_range(10)));
            endcase
            burst = 1'b0;
            for (i = 0; i < PHASE_BEATS && sent < RANDOM_BEATS; i++) begin
                if (i % 40 == 0)
                    burst = ($urandom_range(2) == 0);
                if (shadow_count >= QUEUE_DEPTH)
                    act = ($urandom_range(99) < 30) ? ACT_REGISTER : ACT_DISPATCH;
                else if (shadow_count < 3)
                    act = ($urandom_range(99) < 75) ? ACT_REGISTER : ACT_DISPATCH;
                else
                    act = ($urandom_range(99) < 50) ? ACT_REGISTER : ACT_DISPATCH;
                case ($urandom_range(5))
                    0:       prio = shadow_threshold;
                    1:       prio = shadow_threshold - 8'd1;
                    2:       prio = shadow_threshold + 8'd1;
                    3:       prio = PRIO_W'($urandom_range(7));
                    default: prio = PRIO_W'($urandom);
                endcase
                send_beat(act, PID_W'($urandom), prio, burst ? 0 : random_gap());
                sent++;
            end
            drain_results();
            phase++;
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_in        <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;

        err_count          = 0;
        n_inserted         = 0;
        n_dropped          = 0;
        n_dispatched       = 0;
        n_held             = 0;
        n_threshold_writes = 0;
        shadow_count       = 0;
        shadow_threshold   = THRESHOLD_RESET;
        foreach (shadow_slots[k])
            shadow_slots[k] = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_holds();
        test_full_queue();
        test_random_traffic();
        drain_results();

        $display("tb_top: beats inserted %0d, dropped when full %0d, dispatched %0d, held %0d",
                 n_inserted, n_dropped, n_dispatched, n_held);
        $display("tb_top: %0d threshold writes, %0d result errors",
                 n_threshold_writes, err_count);
        if (err_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
